// ----- rtl/bfi_pkg.sv -----
`default_nettype none

package bfi_pkg;

    localparam int POS_WIDTH    = 40;
    localparam int VEL_WIDTH    = 32;
    localparam int ANGLE_WIDTH  = 32;
    localparam int SPIN_W       = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int TRIG_W       = 32;
    localparam int Z_W          = 33;
    localparam int SPLIT_W      = 20;
    localparam int PH_W         = POS_WIDTH - SPLIT_W;
    localparam int PP_W         = POS_WIDTH + TRIG_W;
    localparam int VP_W         = VEL_WIDTH + TRIG_W;
    localparam int VEL_PRE      = 10;
    localparam int POS_SHIFT    = 30;
    localparam int VEL_SHIFT    = 40;
    localparam int TV_W         = ((VP_W + VEL_PRE) > (POS_WIDTH + SPIN_W + 1)
                                  ? (VP_W + VEL_PRE) : (POS_WIDTH + SPIN_W + 1)) + 2;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic [SPIN_W-1:0] SPIN_RESET = 32'd80177662;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    typedef enum logic [0:0] {
        REG_SPIN_RATE = 1'b0
    } reg_idx_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] px;
        logic signed [POS_WIDTH-1:0] py;
        logic [POS_WIDTH-1:0]        pz;
        logic signed [VEL_WIDTH-1:0] vx;
        logic signed [VEL_WIDTH-1:0] vy;
        logic [VEL_WIDTH-1:0]        vz;
    } state_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] xi;
        logic signed [POS_WIDTH-1:0] yi;
        logic [POS_WIDTH-1:0]        pz;
        logic [VEL_WIDTH-1:0]        vz;
        logic signed [VP_W-1:0]      ux;
        logic signed [VP_W-1:0]      uy;
        logic                        clip;
    } rot_t;

    typedef struct packed {
        logic [POS_WIDTH-1:0] pos_x;
        logic [POS_WIDTH-1:0] pos_y;
        logic [POS_WIDTH-1:0] pos_z;
        logic [VEL_WIDTH-1:0] vel_x;
        logic [VEL_WIDTH-1:0] vel_y;
        logic [VEL_WIDTH-1:0] vel_z;
        logic                 clip;
    } res_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] val;
        logic                        clip;
    } pos_sat_t;

    typedef struct packed {
        logic signed [VEL_WIDTH-1:0] val;
        logic                        clip;
    } vel_sat_t;

    // round half up by 2^POS_SHIFT, then clamp to the position width
    function automatic pos_sat_t sat_pos(input logic signed [PP_W-1:0] v);
        logic signed [PP_W-1:0] h;
        logic signed [PP_W-1:0] r;
        pos_sat_t o;
        h = '0;
        h[POS_SHIFT-1] = 1'b1;
        r = v + h;
        r = r >>> POS_SHIFT;
        if ((&r[PP_W-1:POS_WIDTH-1]) || !(|r[PP_W-1:POS_WIDTH-1]))
        begin
            o.val  = r[POS_WIDTH-1:0];
            o.clip = 1'b0;
        end
        else
        begin
            o.val  = r[PP_W-1] ? {1'b1, {(POS_WIDTH-1){1'b0}}}
                               : {1'b0, {(POS_WIDTH-1){1'b1}}};
            o.clip = 1'b1;
        end
        return o;
    endfunction

    function automatic vel_sat_t sat_vel(input logic signed [TV_W-1:0] v);
        logic signed [TV_W-1:0] h;
        logic signed [TV_W-1:0] r;
        vel_sat_t o;
        h = '0;
        h[VEL_SHIFT-1] = 1'b1;
        r = v + h;
        r = r >>> VEL_SHIFT;
        if ((&r[TV_W-1:VEL_WIDTH-1]) || !(|r[TV_W-1:VEL_WIDTH-1]))
        begin
            o.val  = r[VEL_WIDTH-1:0];
            o.clip = 1'b0;
        end
        else
        begin
            o.val  = r[TV_W-1] ? {1'b1, {(VEL_WIDTH-1){1'b0}}}
                               : {1'b0, {(VEL_WIDTH-1){1'b1}}};
            o.clip = 1'b1;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/body_fixed_to_inertial_state_unit.sv -----
`default_nettype none

// Body-fixed to inertial state rotation. Each request carries a position and
// velocity in the frame of a spinning body plus a turn angle (2^32 = one full
// turn); the result is the same state in the inertial frame. x and y of
// position and velocity are rotated by the angle, the velocity picks up the
// spin term (-w*Y for x, +w*X for y, using the clamped inertial position),
// and z passes straight through. Sine and cosine come from a 30-step CORDIC
// with one register stage per step. Any clamped x/y component raises clipped.
// Throughput is one request per clock unless in_stall is high; a request
// passes the input step, 29 CORDIC steps, quadrant map, three rotate stages,
// three spin stages and the output register. A two-entry output buffer
// (output register plus skid) absorbs out_stall; in_stall is that skid
// entry's full flag, so it rises only after the consumer has stalled with a
// result already waiting. spin_rate (rad/s * 2^40, byte address 0) resets to
// Earth's rate 80177662; write it only while no request is in flight.

module body_fixed_to_inertial_state_unit (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bfi_pkg::ANGLE_WIDTH-1:0]     turn_angle,
    input  logic signed [bfi_pkg::POS_WIDTH-1:0] pos_x_fixed,
    input  logic signed [bfi_pkg::POS_WIDTH-1:0] pos_y_fixed,
    input  logic signed [bfi_pkg::POS_WIDTH-1:0] pos_z_fixed,
    input  logic signed [bfi_pkg::VEL_WIDTH-1:0] vel_x_fixed,
    input  logic signed [bfi_pkg::VEL_WIDTH-1:0] vel_y_fixed,
    input  logic signed [bfi_pkg::VEL_WIDTH-1:0] vel_z_fixed,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [bfi_pkg::POS_WIDTH-1:0] pos_x_inert,
    output logic signed [bfi_pkg::POS_WIDTH-1:0] pos_y_inert,
    output logic signed [bfi_pkg::POS_WIDTH-1:0] pos_z_inert,
    output logic signed [bfi_pkg::VEL_WIDTH-1:0] vel_x_inert,
    output logic signed [bfi_pkg::VEL_WIDTH-1:0] vel_y_inert,
    output logic signed [bfi_pkg::VEL_WIDTH-1:0] vel_z_inert,
    output logic                                clipped
);

    // Config register: index sits at paddr[2], low address bits ignored.
    logic [bfi_pkg::SPIN_W-1:0]      spin_reg;
    logic                            reg_hit;

    // Pipeline control: the whole pipe moves together and freezes only when
    // the skid entry is occupied.
    logic                            en;

    logic                            cd_valid;
    logic signed [bfi_pkg::TRIG_W-1:0] cd_cs, cd_sn;
    bfi_pkg::state_t                 in_st, cd_st;
    logic                            rot_valid;
    bfi_pkg::rot_t                   rot;
    logic                            last_valid;
    bfi_pkg::res_t                   last_res;

    logic                            out_valid_reg, skid_valid_reg;
    bfi_pkg::res_t                   out_reg, skid_reg;
    logic                            take;

    assign reg_hit = (bfi_pkg::reg_idx_t'(paddr[2]) == bfi_pkg::REG_SPIN_RATE);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? spin_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spin_reg <= bfi_pkg::SPIN_RESET;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            spin_reg <= pwdata;
        end
    end

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    assign in_st.px = pos_x_fixed;
    assign in_st.py = pos_y_fixed;
    assign in_st.pz = pos_z_fixed;
    assign in_st.vx = vel_x_fixed;
    assign in_st.vy = vel_y_fixed;
    assign in_st.vz = vel_z_fixed;

    bfi_cordic u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .turn_angle (turn_angle),
        .in_st      (in_st),
        .out_valid  (cd_valid),
        .cs         (cd_cs),
        .sn         (cd_sn),
        .out_st     (cd_st)
    );

    bfi_rotate u_rotate (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (cd_valid),
        .cs         (cd_cs),
        .sn         (cd_sn),
        .in_st      (cd_st),
        .out_valid  (rot_valid),
        .out_rot    (rot)
    );

    bfi_spin u_spin (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (rot_valid),
        .in_rot     (rot),
        .spin_rate  (spin_reg),
        .out_valid  (last_valid),
        .out_res    (last_res)
    );

    // Output register with skid: refill from the skid entry first, park a
    // new result in the skid entry when the output register is held.
    assign take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= en && last_valid;
            end
        end
        else if (en && last_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else
            begin
                out_reg <= last_res;
            end
        end
        else if (en && last_valid)
        begin
            skid_reg <= last_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pos_x_inert = out_reg.pos_x;
    assign pos_y_inert = out_reg.pos_y;
    assign pos_z_inert = out_reg.pos_z;
    assign vel_x_inert = out_reg.vel_x;
    assign vel_y_inert = out_reg.vel_y;
    assign vel_z_inert = out_reg.vel_z;
    assign clipped     = out_reg.clip;

`ifndef ASSERT_OFF
    // Skid entry is only ever used behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output register empty");

    // Skid fills only after the consumer stalled on a waiting result.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid entry filled without an output stall");

    // A taken result with a parked one behind it is replaced at once.
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (take && skid_valid_reg) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry did not drain into the output register");
`endif

endmodule

`default_nettype wire

// ----- rtl/bfi_cordic.sv -----
`default_nettype none

module bfi_cordic (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [bfi_pkg::ANGLE_WIDTH-1:0]      turn_angle,
    input  bfi_pkg::state_t                      in_st,
    output logic                                 out_valid,
    output logic signed [bfi_pkg::TRIG_W-1:0]    cs,
    output logic signed [bfi_pkg::TRIG_W-1:0]    sn,
    output bfi_pkg::state_t                      out_st
);

    localparam int N  = bfi_pkg::CORDIC_STEPS;
    localparam int TW = bfi_pkg::TRIG_W;
    localparam int ZW = bfi_pkg::Z_W;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    logic [31:0]             a32;
    logic signed [TW-1:0]    x_reg  [N];
    logic signed [TW-1:0]    y_reg  [N];
    logic signed [ZW-1:0]    z_reg  [N];
    logic [1:0]              q_reg  [N];
    bfi_pkg::state_t         st_reg [N];
    logic                    v_reg  [N];

    logic signed [TW-1:0]    cs_reg, sn_reg;
    logic signed [TW-1:0]    cs_next, sn_next;
    bfi_pkg::state_t         st_out_reg;
    logic                    v_out_reg;

    // bring the angle to 32 bits of turn
    generate
        if (bfi_pkg::ANGLE_WIDTH >= 32)
        begin : g_ang_trunc
            assign a32 = turn_angle[bfi_pkg::ANGLE_WIDTH-1 -: 32];
        end
        else
        begin : g_ang_shift
            assign a32 = {turn_angle, {(32-bfi_pkg::ANGLE_WIDTH){1'b0}}};
        end
    endgenerate

    generate
        for (genvar i = 0; i < N; i++)
        begin : g_step
            logic signed [TW-1:0] x_in, y_in, dx, dy, x_next, y_next;
            logic signed [ZW-1:0] z_in, z_next;
            logic [1:0]           q_in;
            bfi_pkg::state_t      st_in;
            logic                 v_in;

            if (i == 0)
            begin : g_first
                assign x_in  = bfi_pkg::CORDIC_GAIN;
                assign y_in  = '0;
                assign z_in  = ZW'(a32[29:0]);
                assign q_in  = a32[31:30];
                assign st_in = in_st;
                assign v_in  = in_valid;
            end
            else
            begin : g_rest
                assign x_in  = x_reg[i-1];
                assign y_in  = y_reg[i-1];
                assign z_in  = z_reg[i-1];
                assign q_in  = q_reg[i-1];
                assign st_in = st_reg[i-1];
                assign v_in  = v_reg[i-1];
            end

            always_comb
            begin
                dx = y_in >>> i;
                dy = x_in >>> i;
                if (!z_in[ZW-1])
                begin
                    x_next = x_in - dx;
                    y_next = y_in + dy;
                    z_next = z_in - ZW'(bfi_pkg::ATAN_TURN[i]);
                end
                else
                begin
                    x_next = x_in + dx;
                    y_next = y_in - dy;
                    z_next = z_in + ZW'(bfi_pkg::ATAN_TURN[i]);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[i] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i]  <= x_next;
                    y_reg[i]  <= y_next;
                    z_reg[i]  <= z_next;
                    q_reg[i]  <= q_in;
                    st_reg[i] <= st_in;
                end
            end
        end
    endgenerate

    // map the first-quadrant result to the full circle
    always_comb
    begin
        unique case (quad_t'(q_reg[N-1]))
            QUAD_0:
            begin
                cs_next = x_reg[N-1];
                sn_next = y_reg[N-1];
            end
            QUAD_1:
            begin
                cs_next = -y_reg[N-1];
                sn_next = x_reg[N-1];
            end
            QUAD_2:
            begin
                cs_next = -x_reg[N-1];
                sn_next = -y_reg[N-1];
            end
            default:
            begin
                cs_next = y_reg[N-1];
                sn_next = -x_reg[N-1];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_out_reg <= 1'b0;
        end
        else if (en)
        begin
            v_out_reg <= v_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cs_reg     <= cs_next;
            sn_reg     <= sn_next;
            st_out_reg <= st_reg[N-1];
        end
    end

    assign out_valid = v_out_reg;
    assign cs        = cs_reg;
    assign sn        = sn_reg;
    assign out_st    = st_out_reg;

endmodule

`default_nettype wire

// ----- rtl/bfi_rotate.sv -----
`default_nettype none

module bfi_rotate (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [bfi_pkg::TRIG_W-1:0]  cs,
    input  logic signed [bfi_pkg::TRIG_W-1:0]  sn,
    input  bfi_pkg::state_t                    in_st,
    output logic                               out_valid,
    output bfi_pkg::rot_t                      out_rot
);

    localparam int SW  = bfi_pkg::SPLIT_W;
    localparam int HW  = bfi_pkg::PH_W;
    localparam int TW  = bfi_pkg::TRIG_W;
    localparam int PPW = bfi_pkg::PP_W;
    localparam int VPW = bfi_pkg::VP_W;
    localparam int PW  = bfi_pkg::POS_WIDTH;
    localparam int VW  = bfi_pkg::VEL_WIDTH;

    // stage A: partial products
    logic signed [HW-1:0]     pxh, pyh;
    logic signed [SW:0]       pxl, pyl;
    logic signed [HW+TW-1:0]  pxh_c_reg, pyh_s_reg, pxh_s_reg, pyh_c_reg;
    logic signed [SW+TW:0]    pxl_c_reg, pyl_s_reg, pxl_s_reg, pyl_c_reg;
    logic signed [VPW-1:0]    vx_c_reg, vy_s_reg, vx_s_reg, vy_c_reg;
    logic [PW-1:0]            pz_a_reg;
    logic [VW-1:0]            vz_a_reg;
    logic                     v_a_reg;

    // stage B: sums
    logic signed [PPW-1:0]    tx_next, ty_next, tx_reg, ty_reg;
    logic signed [VPW-1:0]    ux_b_reg, uy_b_reg;
    logic [PW-1:0]            pz_b_reg;
    logic [VW-1:0]            vz_b_reg;
    logic                     v_b_reg;

    // stage C: rounded and clamped position
    bfi_pkg::pos_sat_t        sx, sy;
    bfi_pkg::rot_t            rot_reg;
    logic                     v_c_reg;

    assign pxh = in_st.px[PW-1:SW];
    assign pyh = in_st.py[PW-1:SW];
    assign pxl = $signed({1'b0, in_st.px[SW-1:0]});
    assign pyl = $signed({1'b0, in_st.py[SW-1:0]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxh_c_reg <= pxh * cs;
            pxl_c_reg <= pxl * cs;
            pyh_s_reg <= pyh * sn;
            pyl_s_reg <= pyl * sn;
            pxh_s_reg <= pxh * sn;
            pxl_s_reg <= pxl * sn;
            pyh_c_reg <= pyh * cs;
            pyl_c_reg <= pyl * cs;
            vx_c_reg  <= in_st.vx * cs;
            vy_s_reg  <= in_st.vy * sn;
            vx_s_reg  <= in_st.vx * sn;
            vy_c_reg  <= in_st.vy * cs;
            pz_a_reg  <= in_st.pz;
            vz_a_reg  <= in_st.vz;
        end
    end

    always_comb
    begin
        tx_next = (PPW'(pxh_c_reg) <<< SW) + PPW'(pxl_c_reg)
                - (PPW'(pyh_s_reg) <<< SW) - PPW'(pyl_s_reg);
        ty_next = (PPW'(pxh_s_reg) <<< SW) + PPW'(pxl_s_reg)
                + (PPW'(pyh_c_reg) <<< SW) + PPW'(pyl_c_reg);
        sx = bfi_pkg::sat_pos(tx_reg);
        sy = bfi_pkg::sat_pos(ty_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_reg   <= tx_next;
            ty_reg   <= ty_next;
            ux_b_reg <= vx_c_reg - vy_s_reg;
            uy_b_reg <= vx_s_reg + vy_c_reg;
            pz_b_reg <= pz_a_reg;
            vz_b_reg <= vz_a_reg;

            rot_reg.xi   <= sx.val;
            rot_reg.yi   <= sy.val;
            rot_reg.clip <= sx.clip | sy.clip;
            rot_reg.ux   <= ux_b_reg;
            rot_reg.uy   <= uy_b_reg;
            rot_reg.pz   <= pz_b_reg;
            rot_reg.vz   <= vz_b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
        end
        else if (en)
        begin
            v_a_reg <= in_valid;
            v_b_reg <= v_a_reg;
            v_c_reg <= v_b_reg;
        end
    end

    assign out_valid = v_c_reg;
    assign out_rot   = rot_reg;

endmodule

`default_nettype wire

// ----- rtl/bfi_spin.sv -----
`default_nettype none

module bfi_spin (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  bfi_pkg::rot_t                  in_rot,
    input  logic [bfi_pkg::SPIN_W-1:0]     spin_rate,
    output logic                           out_valid,
    output bfi_pkg::res_t                  out_res
);

    localparam int SW  = bfi_pkg::SPLIT_W;
    localparam int HW  = bfi_pkg::PH_W;
    localparam int OW  = bfi_pkg::SPIN_W;
    localparam int TVW = bfi_pkg::TV_W;
    localparam int PW  = bfi_pkg::POS_WIDTH;

    logic signed [OW:0]        om;
    logic signed [HW-1:0]      xh, yh;
    logic signed [SW:0]        xl, yl;

    // stage D: omega products
    logic signed [HW+OW:0]     xh_w_reg, yh_w_reg;
    logic signed [SW+OW+1:0]   xl_w_reg, yl_w_reg;
    bfi_pkg::rot_t             rot_d_reg;
    logic                      v_d_reg;

    // stage E: full-width sums
    logic signed [TVW-1:0]     tvx_next, tvy_next, tvx_reg, tvy_reg;
    bfi_pkg::rot_t             rot_e_reg;
    logic                      v_e_reg;

    // stage F: rounded and clamped velocity
    bfi_pkg::vel_sat_t         svx, svy;
    bfi_pkg::res_t             res_reg;
    logic                      v_f_reg;

    assign om = $signed({1'b0, spin_rate});
    assign xh = in_rot.xi[PW-1:SW];
    assign yh = in_rot.yi[PW-1:SW];
    assign xl = $signed({1'b0, in_rot.xi[SW-1:0]});
    assign yl = $signed({1'b0, in_rot.yi[SW-1:0]});

    always_comb
    begin
        tvx_next = (TVW'(rot_d_reg.ux) <<< bfi_pkg::VEL_PRE)
                 - (TVW'(yh_w_reg) <<< SW) - TVW'(yl_w_reg);
        tvy_next = (TVW'(rot_d_reg.uy) <<< bfi_pkg::VEL_PRE)
                 + (TVW'(xh_w_reg) <<< SW) + TVW'(xl_w_reg);
        svx = bfi_pkg::sat_vel(tvx_reg);
        svy = bfi_pkg::sat_vel(tvy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xh_w_reg  <= xh * om;
            xl_w_reg  <= xl * om;
            yh_w_reg  <= yh * om;
            yl_w_reg  <= yl * om;
            rot_d_reg <= in_rot;

            tvx_reg   <= tvx_next;
            tvy_reg   <= tvy_next;
            rot_e_reg <= rot_d_reg;

            res_reg.pos_x <= rot_e_reg.xi;
            res_reg.pos_y <= rot_e_reg.yi;
            res_reg.pos_z <= rot_e_reg.pz;
            res_reg.vel_x <= svx.val;
            res_reg.vel_y <= svy.val;
            res_reg.vel_z <= rot_e_reg.vz;
            res_reg.clip  <= rot_e_reg.clip | svx.clip | svy.clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_d_reg <= 1'b0;
            v_e_reg <= 1'b0;
            v_f_reg <= 1'b0;
        end
        else if (en)
        begin
            v_d_reg <= in_valid;
            v_e_reg <= v_d_reg;
            v_f_reg <= v_e_reg;
        end
    end

    assign out_valid = v_f_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ----- dv/body_fixed_to_inertial_state_unit_tb.sv -----
`default_nettype none

module body_fixed_to_inertial_state_unit_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 45;        // pipeline latency plus margin
    localparam int MAX_WAIT       = 16;
    localparam int PW             = bfi_pkg::POS_WIDTH;
    localparam int VW             = bfi_pkg::VEL_WIDTH;
    localparam int AW             = bfi_pkg::ANGLE_WIDTH;
    localparam logic [2:0] ADDR_SPIN_RATE = {bfi_pkg::REG_SPIN_RATE, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED  = 3'd4;  // one past the last register
    localparam int ORBIT_POS = 42000000;       // ~42 km in mm
    localparam int ORBIT_VEL = 11000000;       // 11 km/s in mm/s

    localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};
    localparam logic signed [VW-1:0] VEL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VEL_MIN = {1'b1, {(VW-1){1'b0}}};

    typedef struct packed {
        logic [AW-1:0]      angle;
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic signed [PW-1:0] pz;
        logic signed [VW-1:0] vx;
        logic signed [VW-1:0] vy;
        logic signed [VW-1:0] vz;
    } state_req_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [AW-1:0] turn_angle;
    logic signed [PW-1:0] pos_x_fixed, pos_y_fixed, pos_z_fixed;
    logic signed [VW-1:0] vel_x_fixed, vel_y_fixed, vel_z_fixed;
    logic signed [PW-1:0] pos_x_inert, pos_y_inert, pos_z_inert;
    logic signed [VW-1:0] vel_x_inert, vel_y_inert, vel_z_inert;
    logic clipped;

    state_req_t          pending_reqs[$];
    bfi_pkg::res_t       inertial_expect[$];
    logic [31:0] spin_now;
    logic        quiet;           // when set, neither side idles
    int          error_count;
    int          req_count;
    int          res_count;
    int          clip_count;
    int          send_gap;
    int          recv_gap;
    int          idle_cycles;

    body_fixed_to_inertial_state_unit dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .turn_angle(turn_angle),
        .pos_x_fixed(pos_x_fixed), .pos_y_fixed(pos_y_fixed), .pos_z_fixed(pos_z_fixed),
        .vel_x_fixed(vel_x_fixed), .vel_y_fixed(vel_y_fixed), .vel_z_fixed(vel_z_fixed),
        .out_valid(out_valid), .out_stall(out_stall),
        .pos_x_inert(pos_x_inert), .pos_y_inert(pos_y_inert), .pos_z_inert(pos_z_inert),
        .vel_x_inert(vel_x_inert), .vel_y_inert(vel_y_inert), .vel_z_inert(vel_z_inert),
        .clipped(clipped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Round half up by 2^sh, then clamp to w bits; bit 64 carries the clamp flag.
    function automatic logic [64:0] round_clamp(logic signed [127:0] v, int sh, int w);
        logic signed [127:0] r;
        logic signed [127:0] hi;
        logic [63:0] mask;
        mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        r  = (v + (128'sd1 <<< (sh - 1))) >>> sh;
        hi = r >>> (w - 1);
        if (hi == 0 || hi == -1)
            return {1'b0, r[63:0] & mask};
        if (r < 0)
            return {1'b1, 64'd1 << (w - 1)};
        return {1'b1, mask >> 1};
    endfunction

    // Rotate one body-fixed state into the inertial frame at spin rate w.
    function automatic bfi_pkg::res_t rotate_to_inertial(state_req_t r, logic [31:0] w);
        logic signed [63:0] x, y, z, dx, dy, cs, sn;
        logic signed [127:0] cw, sw, pxw, pyw, vxw, vyw, xiw, yiw, omw, t;
        logic [64:0] sat;
        logic [31:0] a;
        bfi_pkg::res_t o;
        a = r.angle;   // angle width equals 32, so no alignment shift
        x = bfi_pkg::CORDIC_GAIN;
        y = 0;
        z = {34'd0, a[29:0]};
        for (int i = 0; i < bfi_pkg::CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - $signed({32'd0, bfi_pkg::ATAN_TURN[i]});
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + $signed({32'd0, bfi_pkg::ATAN_TURN[i]});
            end
        end
        // map the first-quadrant result by the top two angle bits
        case (a[31:30])
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
        cw  = cs;
        sw  = sn;
        pxw = r.px;
        pyw = r.py;
        vxw = r.vx;
        vyw = r.vy;
        omw = {96'd0, w};
        o.clip = 1'b0;

        sat = round_clamp(pxw * cw - pyw * sw, bfi_pkg::POS_SHIFT, PW);
        o.pos_x = sat[PW-1:0];
        o.clip |= sat[64];
        sat = round_clamp(pxw * sw + pyw * cw, bfi_pkg::POS_SHIFT, PW);
        o.pos_y = sat[PW-1:0];
        o.clip |= sat[64];
        xiw = $signed(o.pos_x);
        yiw = $signed(o.pos_y);

        // transport term uses the clamped inertial position
        t = ((vxw * cw - vyw * sw) <<< bfi_pkg::VEL_PRE) - yiw * omw;
        sat = round_clamp(t, bfi_pkg::VEL_SHIFT, VW);
        o.vel_x = sat[VW-1:0];
        o.clip |= sat[64];
        t = ((vxw * sw + vyw * cw) <<< bfi_pkg::VEL_PRE) + xiw * omw;
        sat = round_clamp(t, bfi_pkg::VEL_SHIFT, VW);
        o.vel_y = sat[VW-1:0];
        o.clip |= sat[64];

        o.pos_z = r.pz;
        o.vel_z = r.vz;
        return o;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH result %0d %s: got %h expected %h", res_count, field, got, want);
        error_count++;
    endtask

    task automatic queue_req(logic [31:0] a, logic signed [PW-1:0] px,
                             logic signed [PW-1:0] py,
                             logic signed [PW-1:0] pz,
                             logic signed [VW-1:0] vx,
                             logic signed [VW-1:0] vy,
                             logic signed [VW-1:0] vz);
        state_req_t r;
        r = '{a, px, py, pz, vx, vy, vz};
        pending_reqs.push_back(r);
    endtask

    function automatic logic signed [PW-1:0] orbit_pos();
        return $signed($urandom_range(0, 2 * ORBIT_POS)) - ORBIT_POS;
    endfunction

    function automatic logic signed [VW-1:0] orbit_vel();
        return $signed($urandom_range(0, 2 * ORBIT_VEL)) - ORBIT_VEL;
    endfunction

    function automatic logic [PW-1:0] any_pos();
        return PW'({$urandom, $urandom});
    endfunction

    // Mostly realistic state vectors, the rest full-range noise that can clip.
    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) < 7)
                queue_req($urandom, orbit_pos(), orbit_pos(), orbit_pos(),
                          orbit_vel(), orbit_vel(), orbit_vel());
            else
                queue_req($urandom, any_pos(), any_pos(), any_pos(),
                          $urandom, $urandom, $urandom);
        end
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SPIN_RATE)
            spin_now = data;
    endtask

    // Driver: hold the request while stalled, then idle a drawn number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        state_req_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                r = '{turn_angle, pos_x_fixed, pos_y_fixed, pos_z_fixed,
                      vel_x_fixed, vel_y_fixed, vel_z_fixed};
                inertial_expect.push_back(rotate_to_inertial(r, spin_now));
                req_count++;
            end
            if (in_valid && in_stall)
            begin
                // hold payload and valid
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                r = pending_reqs.pop_front();
                turn_angle  <= r.angle;
                pos_x_fixed <= r.px;
                pos_y_fixed <= r.py;
                pos_z_fixed <= r.pz;
                vel_x_fixed <= r.vx;
                vel_y_fixed <= r.vy;
                vel_z_fixed <= r.vz;
                in_valid    <= 1'b1;
                send_gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check each accepted result, stall a drawn number of cycles after it.
    always @(posedge clk or negedge rst_n)
    begin
        bfi_pkg::res_t want;
        logic accepted;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap = 0;
            idle_cycles = 0;
        end
        else
        begin
            accepted = (out_valid && !out_stall) || (in_valid && !in_stall);
            if (out_valid && !out_stall)
            begin
                if (inertial_expect.size() == 0)
                begin
                    $display("UNEXPECTED result %0d with nothing pending", res_count);
                    error_count++;
                end
                else
                begin
                    want = inertial_expect.pop_front();
                    if (pos_x_inert !== want.pos_x) report_mismatch("pos_x", pos_x_inert, want.pos_x);
                    if (pos_y_inert !== want.pos_y) report_mismatch("pos_y", pos_y_inert, want.pos_y);
                    if (pos_z_inert !== want.pos_z) report_mismatch("pos_z", pos_z_inert, want.pos_z);
                    if (vel_x_inert !== want.vel_x) report_mismatch("vel_x", vel_x_inert, want.vel_x);
                    if (vel_y_inert !== want.vel_y) report_mismatch("vel_y", vel_y_inert, want.vel_y);
                    if (vel_z_inert !== want.vel_z) report_mismatch("vel_z", vel_z_inert, want.vel_z);
                    if (clipped !== want.clip) report_mismatch("clipped", clipped, want.clip);
                    if (want.clip)
                        clip_count++;
                end
                res_count++;
                recv_gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;

            // advance the watchdog only while nothing moves
            idle_cycles = accepted ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding",
                         inertial_expect.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] rates [6];
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        in_valid  = 1'b0;
        out_stall = 1'b0;
        turn_angle  = '0;
        pos_x_fixed = '0; pos_y_fixed = '0; pos_z_fixed = '0;
        vel_x_fixed = '0; vel_y_fixed = '0; vel_z_fixed = '0;
        quiet = 1'b0;
        error_count = 0; req_count = 0; res_count = 0; clip_count = 0;
        spin_now = bfi_pkg::SPIN_RESET;
        rates = '{bfi_pkg::SPIN_RESET, 32'd77935763, 32'd0, 32'hFFFFFFFF, $urandom,
                  32'd80177662};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < 6; p++)
        begin
            // first phase runs at the reset rate without a write
            if (p > 0)
                apb_write(ADDR_SPIN_RATE, rates[p]);
            if (p == 2)
                apb_write(ADDR_UNMAPPED, $urandom);   // dropped: no register there
            quiet = (p == 3);

            if (p == 0)
            begin
                // quadrant boundaries and the angle extremes
                queue_req(32'h0000_0000, 40'sd1000000, 40'sd0, 40'sd7, 32'sd1000, 32'sd0, 32'sd5);
                queue_req(32'h4000_0000, 40'sd1000000, 40'sd0, -40'sd7, 32'sd1000, 32'sd0, -32'sd5);
                queue_req(32'h8000_0000, 40'sd0, 40'sd1000000, 40'sd0, 32'sd0, 32'sd1000, 32'sd0);
                queue_req(32'hC000_0000, 40'sd1000000, -40'sd1000000, 40'sd1, -32'sd1000, 32'sd1, 32'sd1);
                queue_req(32'hFFFF_FFFF, 40'sd6378137000, 40'sd0, 40'sd0, 32'sd0, 32'sd7700000, 32'sd0);
                queue_req(32'h0000_0001, 40'sd42164000000, 40'sd0, 40'sd0, 32'sd0, 32'sd3075000, 32'sd0);
                queue_req(32'h2000_0000, 40'sd0, 40'sd0, 40'sd0, 32'sd0, 32'sd0, 32'sd0);
                queue_req(32'h6000_0000, -40'sd1, -40'sd1, -40'sd1, -32'sd1, -32'sd1, -32'sd1);
                // field extremes; rotation of some of these overflows a position axis
                queue_req(32'h2000_0000, POS_MAX, POS_MAX, POS_MAX, VEL_MAX, VEL_MAX, VEL_MAX);
                queue_req(32'hA000_0000, POS_MIN, POS_MIN, POS_MIN, VEL_MIN, VEL_MIN, VEL_MIN);
                queue_req(32'h0000_0000, POS_MAX, POS_MIN, POS_MAX, VEL_MAX, VEL_MIN, VEL_MIN);
                queue_req(32'h8000_0000, POS_MIN, POS_MAX, POS_MIN, VEL_MIN, VEL_MAX, VEL_MAX);
                queue_req(32'h4000_0000, POS_MIN, 40'sd0, 40'sd0, VEL_MIN, 32'sd0, 32'sd0);
                queue_req(32'hC000_0000, 40'sd0, POS_MIN, 40'sd0, 32'sd0, VEL_MIN, 32'sd0);
                // spin term alone, then spin on top of full-scale velocity
                queue_req(32'h1234_5678, POS_MAX, 40'sd0, 40'sd0, 32'sd0, 32'sd0, 32'sd0);
                queue_req(32'h9876_5432, 40'sd0, POS_MAX, 40'sd0, VEL_MAX, VEL_MAX, 32'sd0);
                queue_req(32'h5555_5555, 40'sd12345678901, -40'sd9876543210, 40'sd1,
                          -32'sd7000000, 32'sd3000000, 32'sd2);
                queue_req(32'hAAAA_AAAA, -40'sd12345678901, 40'sd9876543210, -40'sd1,
                          32'sd7000000, -32'sd3000000, -32'sd2);
                queue_random(50);
            end
            else
                queue_random(70);

            while (pending_reqs.size() > 0 || in_valid || inertial_expect.size() > 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end

        $display("Covered %0d requests over 6 spin rates (reset, other body, zero, max,",
                 req_count);
        $display("random, Earth); %0d results checked, %0d of them clipped", res_count, clip_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
